// ===== design/mpfm_pkg.sv =====
`default_nettype none

package mpfm_pkg;

  // Number of sync channels that are measured.
  localparam int CHANNELS = 4;
  // Bits that index the per-channel timestamp store.
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int DATA_W = 32;
  localparam int CHAN_W = 2;
  localparam int ADDR_W = 4;

  // The divider produces one quotient bit per step.
  localparam int DIV_STEPS = DATA_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_PERIOD_LO = 2'd0;
  localparam logic [1:0] REG_PERIOD_HI = 2'd1;
  localparam logic [1:0] REG_RATE_NUM  = 2'd2;

  // Reset values: the rate numerator over 32000 and over 20.
  localparam logic [DATA_W-1:0] RST_RATE_NUM  = 32'd168000000;
  localparam logic [DATA_W-1:0] RST_PERIOD_LO = RST_RATE_NUM / 32000;
  localparam logic [DATA_W-1:0] RST_PERIOD_HI = RST_RATE_NUM / 20;

  typedef struct packed {
    logic [DATA_W-1:0] period_lo;
    logic [DATA_W-1:0] period_hi;
    logic [DATA_W-1:0] rate_numerator;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/mpfm_regs.sv =====
`default_nettype none

module mpfm_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mpfm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mpfm_pkg::DATA_W-1:0]   pwdata,
  output logic      [mpfm_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output mpfm_pkg::cfg_t                     cfg_o
);

  mpfm_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        mpfm_pkg::REG_PERIOD_LO: cfg_d.period_lo      = pwdata;
        mpfm_pkg::REG_PERIOD_HI: cfg_d.period_hi      = pwdata;
        mpfm_pkg::REG_RATE_NUM:  cfg_d.rate_numerator = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mpfm_pkg::REG_PERIOD_LO: prdata = cfg_q.period_lo;
      mpfm_pkg::REG_PERIOD_HI: prdata = cfg_q.period_hi;
      mpfm_pkg::REG_RATE_NUM:  prdata = cfg_q.rate_numerator;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_lo      <= mpfm_pkg::RST_PERIOD_LO;
      cfg_q.period_hi      <= mpfm_pkg::RST_PERIOD_HI;
      cfg_q.rate_numerator <= mpfm_pkg::RST_RATE_NUM;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/mpfm_ctrl.sv =====
`default_nettype none

module mpfm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  mpfm_pkg::dp_status_t      status_i,
  output mpfm_pkg::dp_cmd_t         cmd_o
);

  mpfm_pkg::ctrl_state_e          state_q, state_d;
  logic [mpfm_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                           last_step;

  assign last_step = (cnt_q == mpfm_pkg::CNT_W'(mpfm_pkg::DIV_STEPS - 1));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      mpfm_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.hit) begin
            state_d = mpfm_pkg::S_DIV;
            cnt_d   = '0;
          end
        end
      end
      mpfm_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (last_step) begin
          state_d = mpfm_pkg::S_PUSH;
        end
      end
      mpfm_pkg::S_PUSH: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = mpfm_pkg::S_IDLE;
        end
      end
      default: state_d = mpfm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpfm_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // A hit always starts the divider from its first step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && status_i.hit) |=> (state_q == mpfm_pkg::S_DIV && cnt_q == '0))
    else $error("divider did not start at step zero");

  // The result is handed over only once all quotient bits are done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> $past(state_q == mpfm_pkg::S_DIV && last_step)
                       || $past(state_q == mpfm_pkg::S_PUSH))
    else $error("result loaded before the division finished");

endmodule

`default_nettype wire

// ===== design/mpfm_dp.sv =====
`default_nettype none

module mpfm_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  mpfm_pkg::cfg_t                     cfg_i,
  input  wire logic [mpfm_pkg::CHAN_W-1:0]   channel_i,
  input  wire logic [mpfm_pkg::DATA_W-1:0]   timestamp_i,
  input  mpfm_pkg::dp_cmd_t                  cmd_i,
  output mpfm_pkg::dp_status_t               status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [mpfm_pkg::CHAN_W-1:0]   out_channel_o,
  output logic      [mpfm_pkg::DATA_W-1:0]   period_o,
  output logic      [mpfm_pkg::DATA_W-1:0]   frequency_o
);

  logic [mpfm_pkg::DATA_W-1:0]    last_stamp_q [mpfm_pkg::CHANNELS];
  logic [mpfm_pkg::CH_IDX_W-1:0]  ch_idx;
  logic                           chan_ok;
  logic [mpfm_pkg::DATA_W-1:0]    prev;
  logic [mpfm_pkg::DATA_W-1:0]    elapsed;
  logic                           hit;

  // Working registers of the division.
  logic [mpfm_pkg::CHAN_W-1:0]    ch_q;
  logic [mpfm_pkg::DATA_W-1:0]    elapsed_q;
  logic [mpfm_pkg::DATA_W-1:0]    rem_q, rem_d;
  logic [mpfm_pkg::DATA_W-1:0]    quo_q, quo_d;
  logic [mpfm_pkg::DATA_W:0]      trial;
  logic [mpfm_pkg::DATA_W:0]      shifted;

  // Output register.
  logic                           out_valid_q, out_valid_d;
  logic [mpfm_pkg::CHAN_W-1:0]    out_channel_q;
  logic [mpfm_pkg::DATA_W-1:0]    period_q;
  logic [mpfm_pkg::DATA_W-1:0]    freq_q;

  assign ch_idx  = mpfm_pkg::CH_IDX_W'(channel_i);
  assign chan_ok = (32'(channel_i) < 32'(mpfm_pkg::CHANNELS));
  assign prev    = last_stamp_q[ch_idx];
  assign elapsed = timestamp_i - prev;
  assign hit     = chan_ok && (timestamp_i > prev) &&
                   (elapsed > cfg_i.period_lo) && (elapsed < cfg_i.period_hi);

  assign status_o.hit      = hit;
  assign status_o.out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mpfm_pkg::CHANNELS; i++) begin
        last_stamp_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < mpfm_pkg::CHANNELS; i++) begin
        if (cmd_i.load && chan_ok && ch_idx == mpfm_pkg::CH_IDX_W'(i)) begin
          last_stamp_q[i] <= timestamp_i;
        end
      end
    end
  end

  // Restoring division: one quotient bit enters from the right each step while
  // the numerator bits leave from the left into the partial remainder.
  assign shifted = {rem_q, quo_q[mpfm_pkg::DATA_W-1]};
  assign trial   = shifted - {1'b0, elapsed_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.load) begin
      rem_d = '0;
      quo_d = cfg_i.rate_numerator;
    end else if (cmd_i.div_step) begin
      if (trial[mpfm_pkg::DATA_W]) begin
        rem_d = shifted[mpfm_pkg::DATA_W-1:0];
        quo_d = {quo_q[mpfm_pkg::DATA_W-2:0], 1'b0};
      end else begin
        rem_d = trial[mpfm_pkg::DATA_W-1:0];
        quo_d = {quo_q[mpfm_pkg::DATA_W-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.load) begin
      ch_q      <= channel_i;
      elapsed_q <= elapsed;
    end
    if (cmd_i.out_load) begin
      out_channel_q <= ch_q;
      period_q      <= elapsed_q;
      freq_q        <= quo_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign period_o      = period_q;
  assign frequency_o   = freq_q;

  // A captured period always lies above the lower bound of the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && hit) |=> (elapsed_q > $past(cfg_i.period_lo)))
    else $error("period captured outside the window");

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== design/multichannel_period_frequency_meter_top.sv =====
`default_nettype none

// Reciprocal period and frequency meter for four sync channels. Each input
// transaction carries a channel number and the value of a free-running 32-bit
// cycle counter taken at an edge on that channel. The block remembers the last
// timestamp of every channel (all zero after reset) and always replaces it with
// the new one. When the new timestamp is strictly greater than the stored one
// and the difference lies strictly between the lower and the upper period
// bound, one output transaction carries the channel, the period and the
// integer quotient rate_numerator / period; otherwise, including on counter
// wrap, no output transaction is produced. An input that yields no result
// leaves the block idle, so the next input can follow in the very next cycle.
// An input that yields a result is accepted and checked against the window,
// then runs 32 steps of a radix-2 restoring divider that produces one quotient
// bit per cycle, and finally its quotient moves into the output register. The
// output register holds a finished result while the receiver stalls, so a new
// input is taken and divided meanwhile; only the hand-over of the next result
// waits for it. The registers sit on an APB-style port at byte addresses 0
// (lower period bound), 4 (upper period bound) and 8 (rate_numerator); write
// them only while the block is idle.

module multichannel_period_frequency_meter_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mpfm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mpfm_pkg::DATA_W-1:0]   pwdata,
  output logic      [mpfm_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  // Edge event input.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [mpfm_pkg::CHAN_W-1:0]   channel_i,
  input  wire logic [mpfm_pkg::DATA_W-1:0]   timestamp_i,
  // Measurement output.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [mpfm_pkg::CHAN_W-1:0]   out_channel_o,
  output logic      [mpfm_pkg::DATA_W-1:0]   period_o,
  output logic      [mpfm_pkg::DATA_W-1:0]   frequency_o
);

  mpfm_pkg::cfg_t        cfg;
  mpfm_pkg::dp_cmd_t     cmd;
  mpfm_pkg::dp_status_t  status;

  // Configuration registers with their reset values.
  mpfm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The controller accepts an input only when idle and sequences the divider
  // and the hand-over into the output register.
  mpfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the timestamp store, the window check, the divider and
  // the output register.
  mpfm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .channel_i     (channel_i),
    .timestamp_i   (timestamp_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_channel_o (out_channel_o),
    .period_o      (period_o),
    .frequency_o   (frequency_o)
  );

endmodule

`default_nettype wire

// ===== dv/mpfm_meter_checker.sv =====
`timescale 1ns / 1ps

module mpfm_meter_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel_i,
  input  wire logic                        penable_i,
  input  wire logic                        pwrite_i,
  input  wire logic                        pready_i,
  input  wire logic [mpfm_pkg::ADDR_W-1:0] paddr_i,
  input  wire logic [mpfm_pkg::DATA_W-1:0] pwdata_i,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_stall_i,
  input  wire logic [mpfm_pkg::CHAN_W-1:0] channel_i,
  input  wire logic [mpfm_pkg::DATA_W-1:0] timestamp_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_stall_i,
  input  wire logic [mpfm_pkg::CHAN_W-1:0] meas_channel_i,
  input  wire logic [mpfm_pkg::DATA_W-1:0] period_i,
  input  wire logic [mpfm_pkg::DATA_W-1:0] frequency_i,
  output int unsigned                      outstanding_o,
  output int unsigned                      mismatch_count_o
);

  typedef struct packed {
    logic [mpfm_pkg::CHAN_W-1:0] chan;
    logic [mpfm_pkg::DATA_W-1:0] period;
    logic [mpfm_pkg::DATA_W-1:0] freq;
  } meas_t;

  mpfm_pkg::cfg_t              cfg;
  logic [mpfm_pkg::DATA_W-1:0] last_stamp_q [mpfm_pkg::CHANNELS];
  meas_t                       meas_q [$];

  // The stamp is stored whatever happens; a measurement is due only when the
  // counter moved forward by a count strictly inside the period window.
  task automatic predict_edge(input logic [mpfm_pkg::CHAN_W-1:0] ch,
                              input logic [mpfm_pkg::DATA_W-1:0] now);
    logic [mpfm_pkg::DATA_W-1:0] elapsed;
    meas_t                       m;
    if (int'(ch) < mpfm_pkg::CHANNELS) begin
      elapsed = now - last_stamp_q[ch];
      if (now > last_stamp_q[ch] && elapsed > cfg.period_lo &&
          elapsed < cfg.period_hi) begin
        m.chan   = ch;
        m.period = elapsed;
        m.freq   = cfg.rate_numerator / elapsed;
        meas_q.push_back(m);
      end
      last_stamp_q[ch] = now;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    meas_t got;
    meas_t want;
    if (!rst_ni) begin
      cfg.period_lo      = 32'd5250;
      cfg.period_hi      = 32'd8400000;
      cfg.rate_numerator = 32'd168000000;
      foreach (last_stamp_q[i]) last_stamp_q[i] = '0;
      meas_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[mpfm_pkg::ADDR_W-1:2])
          mpfm_pkg::REG_PERIOD_LO: cfg.period_lo = pwdata_i;
          mpfm_pkg::REG_PERIOD_HI: cfg.period_hi = pwdata_i;
          mpfm_pkg::REG_RATE_NUM:  cfg.rate_numerator = pwdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_edge(channel_i, timestamp_i);
      if (out_valid_i && !out_stall_i) begin
        got = '{chan: meas_channel_i, period: period_i, freq: frequency_i};
        if (meas_q.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: unexpected measurement ch=%0d period=%0d freq=%0d",
                     $realtime, got.chan, got.period, got.freq);
          mismatch_count_o++;
        end else begin
          want = meas_q.pop_front();
          if (got !== want) begin
            if (mismatch_count_o < 10) begin
              $write("%0t: measurement mismatch: expected ch=%0d period=%0d freq=%0d, ",
                     $realtime, want.chan, want.period, want.freq);
              $display("got ch=%0d period=%0d freq=%0d",
                       got.chan, got.period, got.freq);
            end
            mismatch_count_o++;
          end
        end
      end
    end
    outstanding_o = meas_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

// Top of the meter testbench. It drives edge events and register writes into
// the block, plays a receiver that stalls at random, and gives the verdict.
// All prediction and comparison lives in the checker instantiated beside the
// block, which hands back how many measurements are still awaited and how
// many mismatches it saw.
module tb_top;

  // Address slot past the last register; writes there must be dropped.
  localparam logic [1:0] REG_SPARE = 2'd3;
  // Cycles without any transaction before the run is declared hung.
  localparam int unsigned IDLE_LIMIT = 2000;
  // Cycles allowed after the last awaited result before touching registers.
  localparam int unsigned SETTLE_CYCLES = 40;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [mpfm_pkg::ADDR_W-1:0] paddr;
  logic [mpfm_pkg::DATA_W-1:0] pwdata;
  logic [mpfm_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [mpfm_pkg::CHAN_W-1:0] channel_i;
  logic [mpfm_pkg::DATA_W-1:0] timestamp_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [mpfm_pkg::CHAN_W-1:0] out_channel_o;
  logic [mpfm_pkg::DATA_W-1:0] period_o;
  logic [mpfm_pkg::DATA_W-1:0] frequency_o;

  int unsigned outstanding;
  int unsigned mismatch_count;

  // Stimulus bookkeeping: the last stamp sent per channel and the current
  // window, so that most random edges land inside it.
  logic [mpfm_pkg::DATA_W-1:0] sent_stamp [mpfm_pkg::CHANNELS];
  logic [mpfm_pkg::DATA_W-1:0] win_min;
  logic [mpfm_pkg::DATA_W-1:0] win_max;
  // While calm is set, neither side inserts idle cycles.
  bit                          calm;
  int unsigned                 rcv_hold;
  int unsigned                 idle_cycles = 0;

  multichannel_period_frequency_meter_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .channel_i     (channel_i),
    .timestamp_i   (timestamp_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_channel_o (out_channel_o),
    .period_o      (period_o),
    .frequency_o   (frequency_o)
  );

  mpfm_meter_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .channel_i        (channel_i),
    .timestamp_i      (timestamp_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .meas_channel_i   (out_channel_o),
    .period_i         (period_o),
    .frequency_i      (frequency_o),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatch_count)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Receiver. After every accepted measurement it draws how long to hold off
  // the next one, and now and then it stalls on its own even when idle.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) rcv_hold = calm ? 0 : $urandom_range(6, 0);
  end

  always @(negedge clk_i) begin
    if (rcv_hold != 0) begin
      out_stall_i <= 1'b1;
      rcv_hold--;
    end else begin
      out_stall_i <= !calm && ($urandom_range(7, 0) == 0);
    end
  end

  // Watchdog: any transaction on any port restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sends one edge event. The valid stays high from one transaction to the
  // next when no gap is drawn, so back-to-back edges are exercised as well.
  task automatic send_edge(input logic [mpfm_pkg::CHAN_W-1:0] ch,
                           input logic [mpfm_pkg::DATA_W-1:0] ts);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(6, 0);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    channel_i   <= ch;
    timestamp_i <= ts;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_stamp[ch] = ts;
  endtask

  // Stops sending and waits until every awaited measurement has come out,
  // then lets the block settle. The count is read at the falling edge so it
  // never races the checker's update.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register write: a setup phase, then an access phase.
  task automatic write_reg(input logic [1:0] idx, input logic [mpfm_pkg::DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mpfm_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(input logic [mpfm_pkg::DATA_W-1:0] min_p,
                              input logic [mpfm_pkg::DATA_W-1:0] max_p,
                              input logic [mpfm_pkg::DATA_W-1:0] rate);
    wait_drained();
    write_reg(mpfm_pkg::REG_PERIOD_LO, min_p);
    write_reg(mpfm_pkg::REG_PERIOD_HI, max_p);
    write_reg(mpfm_pkg::REG_RATE_NUM, rate);
    win_min = min_p;
    win_max = max_p;
  endtask

  // Random edges. Most advance the channel's stamp by a count inside the
  // window so measurements are frequent; the rest are full random stamps
  // (wrap or out of window), repeated stamps, counts right at the window
  // edges, and stamps that step backward.
  task automatic run_random(input int unsigned n_items, input bit mid_pause);
    logic [mpfm_pkg::CHAN_W-1:0] ch;
    logic [mpfm_pkg::DATA_W-1:0] base;
    logic [mpfm_pkg::DATA_W-1:0] ts;
    longint unsigned             lo;
    longint unsigned             hi;
    bit                          window_ok;
    int unsigned                 pick;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 64 == 0) calm = ($urandom_range(3, 0) == 0);
      // Pause here until the block has delivered everything it owes.
      if (mid_pause && i == n_items / 2) wait_drained();
      ch        = mpfm_pkg::CHAN_W'($urandom_range(mpfm_pkg::CHANNELS - 1, 0));
      base      = sent_stamp[ch];
      lo        = {32'd0, win_min} + 1;
      hi        = {32'd0, win_max} - 1;
      window_ok = {32'd0, win_max} > lo;
      pick      = $urandom_range(9, 0);
      if (pick <= 5 && window_ok) begin
        if (hi - lo > 20000 && $urandom_range(1, 0) == 0)
          ts = base + win_min + 1 + $urandom_range(20000, 0);
        else
          ts = base + $urandom_range(hi[31:0], lo[31:0]);
      end else if (pick <= 5) begin
        ts = base + $urandom_range(100000, 1);
      end else if (pick == 6) begin
        ts = $urandom;
      end else if (pick == 7) begin
        ts = base;
      end else if (pick == 8) begin
        case ($urandom_range(3, 0))
          0:       ts = base + win_min;
          1:       ts = base + win_min + 1;
          2:       ts = base + win_max - 1;
          default: ts = base + win_max;
        endcase
      end else begin
        ts = base - $urandom_range(1000, 1);
      end
      send_edge(ch, ts);
    end
  endtask

  initial begin
    logic [mpfm_pkg::DATA_W-1:0] rnd_min;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    channel_i   = '0;
    timestamp_i = '0;
    out_stall_i = 1'b0;
    calm        = 1'b0;
    rcv_hold    = 0;
    foreach (sent_stamp[i]) sent_stamp[i] = '0;
    win_min = mpfm_pkg::RST_PERIOD_LO;
    win_max = mpfm_pkg::RST_PERIOD_HI;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset window: stamps start at zero, so a zero stamp is an equal stamp.
    send_edge(2'd0, 32'd0);
    send_edge(2'd0, 32'd5251);                    // one past the lower bound
    send_edge(2'd0, 32'd10501);                   // exactly the lower bound
    send_edge(2'd0, 32'd10501 + 32'd8399999);     // one below the upper bound
    send_edge(2'd1, 32'd8400000);                 // exactly the upper bound
    send_edge(2'd1, 32'd8405251);
    send_edge(2'd1, 32'd100);                     // counter wrap
    send_edge(2'd2, 32'hFFFF_FFFF);               // far outside the window
    send_edge(2'd2, 32'd0);                       // wrap back to zero
    send_edge(2'd3, 32'd168000);
    send_edge(2'd3, 32'd173251);

    // Widest window and largest numerator: a period of one counter tick gives
    // the full numerator back.
    apply_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_edge(2'd0, sent_stamp[0] + 1);
    send_edge(2'd1, 32'hFFFF_FFFF);
    send_edge(2'd2, 32'hFFFF_FFFF);               // count equals the upper bound
    send_edge(2'd3, 32'h8000_0000);

    // Zero numerator, plus a write to the empty slot that must change nothing.
    apply_config(32'd0, 32'hFFFF_FFFF, 32'd0);
    write_reg(REG_SPARE, 32'h5A5A_A5A5);
    send_edge(2'd0, sent_stamp[0] + 7);
    send_edge(2'd3, 32'hFFFF_FFFE);

    // Inverted window: nothing may be measured.
    apply_config(32'hFFFF_FFFF, 32'd0, 32'hA5A5_5A5A);
    send_edge(2'd0, sent_stamp[0] + 1000);
    send_edge(2'd1, 32'd0);

    apply_config(mpfm_pkg::RST_PERIOD_LO, mpfm_pkg::RST_PERIOD_HI, mpfm_pkg::RST_RATE_NUM);
    run_random(300, 1'b1);

    apply_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(250, 1'b0);

    rnd_min = $urandom_range(60000, 0);
    apply_config(rnd_min, rnd_min + $urandom_range(500000, 2), $urandom);
    run_random(250, 1'b0);

    // Equal bounds close the window as well.
    apply_config(32'd50000, 32'd50000, $urandom);
    run_random(100, 1'b0);

    apply_config(32'd1, 32'd3000, $urandom);
    run_random(200, 1'b0);

    apply_config(32'd0, 32'hFFFF_FFFF, 32'd0);
    run_random(100, 1'b0);

    apply_config(mpfm_pkg::RST_PERIOD_LO, mpfm_pkg::RST_PERIOD_HI, mpfm_pkg::RST_RATE_NUM);
    run_random(100, 1'b0);

    wait_drained();
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
